[src/stt_pkg.sv]
// Package for the software timer table: codes, entry layout and the result push record.
// No dependencies; every other file of the block imports it.
package stt_pkg;

  localparam int SlotsDef = 16;
  localparam int MaxOut   = 16;

  localparam logic [1:0] KindAdd  = 2'd0;
  localparam logic [1:0] KindDel  = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;

  localparam logic [1:0] ReplyAdd   = 2'd0;
  localparam logic [1:0] ReplyDel   = 2'd1;
  localparam logic [1:0] ReplyFired = 2'd2;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatNoId  = 2'd2;

  typedef struct packed {
    logic        periodic;
    logic [15:0] ident;
    logic [31:0] start;
    logic [30:0] delay;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] id;
    logic [1:0]  status;
    logic        last;
  } push_t;

endpackage

[src/stt_mem.sv]
// Timer entry memory: one write port and one read port with registered read data.
// Depends on stt_pkg for the entry layout.
module stt_mem import stt_pkg::*; #(
  parameter int Depth = SlotsDef,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/stt_ctrl.sv]
// Request sequencer of the timer table: adds, and a compacting scan for deletes and ticks.
// Depends on stt_pkg; drives the entry memory ports and the result push record.
module stt_ctrl import stt_pkg::*; #(
  parameter int Slots = SlotsDef,
  localparam int AddrW = $clog2(Slots),
  localparam int CntW  = $clog2(Slots + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic             timer_type_i,
  input  logic [30:0]      delay_i,
  input  logic [15:0]      target_id_i,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  entry_t           mem_rdata_i,
  input  logic             out_free_i,
  output push_t            push_o
);

  localparam int FireW = $clog2(MaxOut + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [31:0]      time_q, time_d;
  logic [15:0]      next_id_q, next_id_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  wr_ptr_q, wr_ptr_d;
  logic             rd_vld_q, rd_vld_d;
  logic             is_tick_q, is_tick_d;
  logic             found_q, found_d;
  logic [15:0]      tid_q, tid_d;
  logic             pend_vld_q, pend_vld_d;
  logic [15:0]      pend_id_q, pend_id_d;
  logic [FireW-1:0] fired_q, fired_d;
  logic [1:0]       rep_kind_q, rep_kind_d;
  logic [15:0]      rep_id_q, rep_id_d;
  logic [1:0]       rep_status_q, rep_status_d;

  logic        accept;
  logic [31:0] elapsed;
  logic        due, fire, hit, stall, drop, process, scan_done;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed   = time_q - mem_rdata_i.start;
  assign due       = elapsed >= {1'b0, mem_rdata_i.delay};
  assign fire      = is_tick_q && due && (fired_q < FireW'(MaxOut));
  assign hit       = !is_tick_q && !found_q && (mem_rdata_i.ident == tid_q);
  assign stall     = rd_vld_q && fire && pend_vld_q && !out_free_i;
  assign drop      = hit || (fire && !mem_rdata_i.periodic);
  assign process   = (state_q == StScan) && rd_vld_q && !stall;
  assign scan_done = !rd_vld_q && (rd_ptr_q == count_q);

  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    next_id_d    = next_id_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    rd_vld_d     = rd_vld_q;
    is_tick_d    = is_tick_q;
    found_d      = found_q;
    tid_d        = tid_q;
    pend_vld_d   = pend_vld_q;
    pend_id_d    = pend_id_q;
    fired_d      = fired_q;
    rep_kind_d   = rep_kind_q;
    rep_id_d     = rep_id_q;
    rep_status_d = rep_status_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = wr_ptr_q[AddrW-1:0];
    mem_wdata_o  = mem_rdata_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = rd_ptr_q[AddrW-1:0];
    push_o       = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          rd_ptr_d   = '0;
          wr_ptr_d   = '0;
          rd_vld_d   = 1'b0;
          found_d    = 1'b0;
          pend_vld_d = 1'b0;
          fired_d    = '0;
          tid_d      = target_id_i;
          unique case (kind_i)
            KindAdd: begin
              rep_kind_d = ReplyAdd;
              state_d    = StEmit;
              if (count_q == CntW'(Slots)) begin
                rep_id_d     = '0;
                rep_status_d = StatFull;
              end else begin
                mem_we_o             = 1'b1;
                mem_waddr_o          = count_q[AddrW-1:0];
                mem_wdata_o.periodic = timer_type_i;
                mem_wdata_o.ident    = next_id_q;
                mem_wdata_o.start    = time_q;
                mem_wdata_o.delay    = delay_i;
                count_d              = count_q + 1'b1;
                rep_id_d             = next_id_q;
                rep_status_d         = StatOk;
                next_id_d            = next_id_q + 16'd1;
              end
            end
            KindDel: begin
              is_tick_d = 1'b0;
              state_d   = StScan;
            end
            KindTick: begin
              is_tick_d = 1'b1;
              time_d    = time_q + 32'd1;
              state_d   = StScan;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StScan: begin
        if (process) begin
          if (!drop) begin
            mem_we_o          = 1'b1;
            mem_wdata_o.start = fire ? time_q : mem_rdata_i.start;
            wr_ptr_d          = wr_ptr_q + 1'b1;
          end
          if (hit) begin
            found_d = 1'b1;
          end
          if (fire) begin
            push_o.valid  = pend_vld_q;
            push_o.kind   = ReplyFired;
            push_o.id     = pend_id_q;
            push_o.status = StatOk;
            push_o.last   = 1'b0;
            pend_vld_d    = 1'b1;
            pend_id_d     = mem_rdata_i.ident;
            fired_d       = fired_q + 1'b1;
          end
        end
        if (!stall) begin
          mem_re_o = rd_ptr_q < count_q;
          rd_vld_d = mem_re_o;
          if (mem_re_o) begin
            rd_ptr_d = rd_ptr_q + 1'b1;
          end
        end
        if (scan_done) begin
          count_d = wr_ptr_q;
          if (is_tick_q) begin
            rep_kind_d   = ReplyFired;
            rep_id_d     = pend_id_q;
            rep_status_d = StatOk;
            state_d      = pend_vld_q ? StEmit : StIdle;
          end else begin
            rep_kind_d   = ReplyDel;
            rep_id_d     = tid_q;
            rep_status_d = found_q ? StatOk : StatNoId;
            state_d      = StEmit;
          end
        end
      end

      StEmit: begin
        if (out_free_i) begin
          push_o.valid  = 1'b1;
          push_o.kind   = rep_kind_q;
          push_o.id     = rep_id_q;
          push_o.status = rep_status_q;
          push_o.last   = 1'b1;
          state_d       = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      time_q     <= '0;
      next_id_q  <= '0;
      count_q    <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      rd_vld_q   <= 1'b0;
      is_tick_q  <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      fired_q    <= '0;
    end else begin
      state_q    <= state_d;
      time_q     <= time_d;
      next_id_q  <= next_id_d;
      count_q    <= count_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_vld_q   <= rd_vld_d;
      is_tick_q  <= is_tick_d;
      found_q    <= found_d;
      pend_vld_q <= pend_vld_d;
      fired_q    <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q        <= tid_d;
    pend_id_q    <= pend_id_d;
    rep_kind_q   <= rep_kind_d;
    rep_id_q     <= rep_id_d;
    rep_status_q <= rep_status_d;
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> out_free_i)
    else $error("result pushed while the output register is occupied");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Slots))
    else $error("entry count beyond the table depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) && mem_we_o |-> wr_ptr_q < rd_ptr_q)
    else $error("compaction write overtook the scan read");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o && mem_re_o |-> mem_waddr_o != mem_raddr_o)
    else $error("read and write of the same entry in one cycle");

endmodule

[src/software_timer_table_top.sv]
// An add is written to the entry memory when taken; its reply goes via the emit state
// to the output register, waiting while it is occupied. A delete or tick walks the live
// entries, one per cycle while no fired result waits for the output to be taken.
// New requests are taken only in idle, so the single-read-port memory scan sets their pace.
// Reset clears the time and id counters, the entry count and the output valid flag;
// entry memory contents are not cleared, since the count marks which entries are live.
module software_timer_table_top import stt_pkg::*; #(
  parameter int Slots = SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        timer_type_i,
  input  logic [30:0] delay_i,
  input  logic [15:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  reply_kind_o,
  output logic [15:0] timer_id_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int AddrW = $clog2(Slots);

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  logic             out_free;
  push_t            push;
  logic             out_valid_q;
  logic [1:0]       reply_kind_q;
  logic [15:0]      timer_id_q;
  logic [1:0]       status_q;
  logic             last_q;

  stt_mem #(
    .Depth (Slots)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stt_ctrl #(
    .Slots (Slots)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .timer_type_i (timer_type_i),
    .delay_i      (delay_i),
    .target_id_i  (target_id_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .out_free_i   (out_free),
    .push_o       (push)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      reply_kind_q <= push.kind;
      timer_id_q   <= push.id;
      status_q     <= push.status;
      last_q       <= push.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = reply_kind_q;
  assign timer_id_o   = timer_id_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule
